/* rtl/ohrg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ohrg_pkg
// Shared types and constants of the onset histogram rhythm generator.
// ----------------------------------------------------------------------------
package ohrg_pkg;

  localparam int unsigned TIME_BITS  = 48;
  localparam int unsigned MAX_SUBDIV = 8;
  localparam int unsigned MAX_BEATS  = 8;
  localparam int unsigned CELLS      = MAX_SUBDIV * MAX_BEATS;
  localparam int unsigned CELL_AW    = $clog2(CELLS);

  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [15:0] HALF_Q16 = 16'h8000;

  localparam logic [1:0] OP_ONSET = 2'd0;
  localparam logic [1:0] OP_BEAT  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] REG_SUBDIV = 3'd0;
  localparam logic [2:0] REG_BEATS  = 3'd1;
  localparam logic [2:0] REG_DECAY  = 3'd2;
  localparam logic [2:0] REG_EXPO   = 3'd3;
  localparam logic [2:0] REG_INV    = 3'd4;
  localparam logic [2:0] REG_SEED   = 3'd5;

  localparam logic [3:0]  SUBDIV_RESET = 4'd4;
  localparam logic [3:0]  BEATS_RESET  = 4'd4;
  localparam logic [16:0] DECAY_RESET  = 17'd49152;
  localparam logic [11:0] EXPO_RESET   = 12'd256;
  localparam logic [31:0] SEED_RESET   = 32'd1;

  typedef enum logic [1:0] {
    CMD_ONSET = 2'd0,
    CMD_BEAT  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]           operation;
    logic [TIME_BITS-1:0] event_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0] slot;
    logic       last;
  } out_item_t;

  typedef struct packed {
    cmd_e                 kind;
    logic [TIME_BITS-1:0] t;
  } cmd_t;

  // clamped register values as the datapath uses them
  typedef struct packed {
    logic [3:0]  subdiv;
    logic [3:0]  beats;
    logic [16:0] decay;
    logic [11:0] expo;
    logic        inv;
    logic [31:0] seed;
  } cfg_t;

endpackage
`default_nettype wire

/* rtl/onset_histogram_rhythm_generator_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// onset_histogram_rhythm_generator_unit
// Onset histogram rhythm generator: top level with register file.
// ----------------------------------------------------------------------------
// Onset and clear commands are handled in the sequencer's idle state; a
// two-entry input queue buffers commands while the sequencer is busy. A beat
// that is ignored or is the first one is handled there too. Otherwise the
// sequencer accepts the beat, runs the quantizer's subtract loop for each
// queued onset (up to q, the rounded subdivision, capped at S) until the ring
// runs empty, decays the S cells of the histogram and advances the pattern
// position. Then per subdivision it runs the shaping chain, set by the 17-step
// square root unit and the shared 17x17 multiplier, and at the output gives
// one note per cycle while not stalled. Notes of one beat come out in
// ascending slot order with last set on the final one.
module onset_histogram_rhythm_generator_unit #(
  parameter int unsigned ONSET_DEPTH = 128
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ohrg_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ohrg_pkg::out_item_t      out_item_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i
);

  logic [3:0]     subdiv_q, beats_q;
  logic [16:0]    decay_q;
  logic [11:0]    expo_q;
  logic           inv_q;
  logic [31:0]    seed_q;
  ohrg_pkg::cfg_t cfg;
  logic           cmd_valid, cmd_ready;
  ohrg_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subdiv_q <= ohrg_pkg::SUBDIV_RESET;
      beats_q  <= ohrg_pkg::BEATS_RESET;
      decay_q  <= ohrg_pkg::DECAY_RESET;
      expo_q   <= ohrg_pkg::EXPO_RESET;
      inv_q    <= 1'b0;
      seed_q   <= ohrg_pkg::SEED_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ohrg_pkg::REG_SUBDIV: subdiv_q <= cfg_data_i[3:0];
        ohrg_pkg::REG_BEATS:  beats_q  <= cfg_data_i[3:0];
        ohrg_pkg::REG_DECAY:  decay_q  <= cfg_data_i[16:0];
        ohrg_pkg::REG_EXPO:   expo_q   <= cfg_data_i[11:0];
        ohrg_pkg::REG_INV:    inv_q    <= cfg_data_i[0];
        ohrg_pkg::REG_SEED:   seed_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.subdiv = (subdiv_q == 4'd0) ? 4'd1 :
                 (subdiv_q > 4'(ohrg_pkg::MAX_SUBDIV)) ? 4'(ohrg_pkg::MAX_SUBDIV) : subdiv_q;
    cfg.beats  = (beats_q == 4'd0) ? 4'd1 :
                 (beats_q > 4'(ohrg_pkg::MAX_BEATS)) ? 4'(ohrg_pkg::MAX_BEATS) : beats_q;
    cfg.decay  = (decay_q > ohrg_pkg::ONE_Q16) ? ohrg_pkg::ONE_Q16 : decay_q;
    cfg.expo   = expo_q;
    cfg.inv    = inv_q;
    cfg.seed   = (seed_q == 32'd0) ? 32'd1 : seed_q;
  end

  ohrg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  ohrg_back #(
    .ONSET_DEPTH (ONSET_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

/* rtl/ohrg_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ohrg_front
// Input side: decodes operations and queues commands for the sequencer.
// ----------------------------------------------------------------------------
module ohrg_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ohrg_pkg::in_item_t in_item_i,
  output logic                   cmd_valid_o,
  output ohrg_pkg::cmd_t         cmd_o,
  input  wire logic              cmd_ready_i
);

  ohrg_pkg::cmd_t ent_q [2];
  logic           wr_q, wr_d, rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop, keep;
  ohrg_pkg::cmd_t dec;

  always_comb begin
    keep = 1'b1;
    dec.t = in_item_i.event_time;
    dec.kind = ohrg_pkg::CMD_ONSET;
    case (in_item_i.operation)
      ohrg_pkg::OP_ONSET: dec.kind = ohrg_pkg::CMD_ONSET;
      ohrg_pkg::OP_BEAT:  dec.kind = ohrg_pkg::CMD_BEAT;
      ohrg_pkg::OP_CLEAR: dec.kind = ohrg_pkg::CMD_CLEAR;
      default:            keep = 1'b0;
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[rd_q];
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = 2'(cnt_q + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= dec;
    end
  end

endmodule
`default_nettype wire

/* rtl/ohrg_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ohrg_back
// Sequencer: onset ring, quantizer, histogram decay, shaping and note draw.
// ----------------------------------------------------------------------------
module ohrg_back #(
  parameter int unsigned ONSET_DEPTH = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ohrg_pkg::cfg_t     cfg_i,
  input  wire logic               cmd_valid_i,
  input  wire ohrg_pkg::cmd_t     cmd_i,
  output logic                    cmd_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ohrg_pkg::out_item_t     out_item_o
);

  localparam int unsigned PW = $clog2(ONSET_DEPTH);
  localparam int unsigned CW = $clog2(ONSET_DEPTH + 1);
  localparam int unsigned TB = ohrg_pkg::TIME_BITS;
  localparam int unsigned AW = ohrg_pkg::CELL_AW;

  typedef enum logic [17:0] {
    ST_IDLE = 18'h00001,
    ST_RING = 18'h00002,
    ST_OFF  = 18'h00004,
    ST_QNT  = 18'h00008,
    ST_DRD  = 18'h00010,
    ST_DMUL = 18'h00020,
    ST_DWR  = 18'h00040,
    ST_ADV  = 18'h00080,
    ST_GRD  = 18'h00100,
    ST_GX   = 18'h00200,
    ST_INT  = 18'h00400,
    ST_SQS  = 18'h00800,
    ST_SQ   = 18'h01000,
    ST_SQE  = 18'h02000,
    ST_MUL  = 18'h04000,
    ST_RND  = 18'h08000,
    ST_PROB = 18'h10000,
    ST_EMIT = 18'h20000
  } state_e;

  function automatic logic [31:0] xs32(input logic [31:0] s);
    logic [31:0] x;
    x = s ^ (s << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  function automatic logic [PW-1:0] wrap(input logic [PW-1:0] p);
    return (p == PW'(ONSET_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  // control
  state_e                 state_q, state_d, ret_q, ret_d;
  logic                   seen_q, seen_d;
  logic [TB-1:0]          last_q, last_d;
  logic [PW-1:0]          wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic [31:0]            rng_q, rng_d;
  logic [ohrg_pkg::CELLS-1:0] cv_q, cv_d;
  logic [7:0]             hits_q, hits_d, mask_q, mask_d;
  logic [3:0]             i_q, i_d, qc_q, qc_d, n_q, n_d, fc_q, fc_d;
  logic                   ovld_q, ovld_d;

  // datapath
  logic [TB-1:0]          prev_q, prev_d;
  logic [30:0]            dur_q, dur_d;
  logic [35:0]            num_q, num_d;
  logic                   neg_q, neg_d, up_q, up_d;
  logic [33:0]            prod_q, prod_d, sv_q, sv_d, sr_q, sr_d, sb_q, sb_d;
  logic [6:0]             v_q, v_d;
  logic [15:0]            r_q, r_d;
  logic [16:0]            y_q, y_d, res_q, res_d, root_q, root_d, mb_q, mb_d;
  ohrg_pkg::out_item_t    oitem_q, oitem_d;

  // memories
  logic [TB-1:0]          ring_mem [ONSET_DEPTH];
  logic [TB-1:0]          ring_rd_q;
  logic                   ring_we;
  logic [15:0]            cell_mem [ohrg_pkg::CELLS];
  logic [15:0]            cell_rd_q, cell_wd;
  logic                   cell_we;
  logic [AW-1:0]          caddr;

  // scratch
  logic [TB-1:0]          diff;
  logic [31:0]            off32, mag, nxt;
  logic [35:0]            den;
  logic [15:0]            x;
  logic [33:0]            sum, tgt, st;
  logic [6:0]             m;
  logic [17:0]            p;
  logic [7:0]             rest;
  logic [2:0]             j;
  logic                   free;

  assign caddr       = AW'(pos_q + AW'(i_q));
  assign cmd_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = ovld_q;
  assign out_item_o  = oitem_q;
  assign x           = cv_q[caddr] ? cell_rd_q : ohrg_pkg::HALF_Q16;
  assign den         = 36'({dur_q, 1'b0});
  assign m           = 7'({3'b0, cfg_i.subdiv} * {3'b0, cfg_i.beats});
  assign free        = !ovld_q || !out_stall_i;

  always_comb begin
    state_d = state_q; ret_d = ret_q; seen_d = seen_q; last_d = last_q;
    wp_d = wp_q; rp_d = rp_q; cnt_d = cnt_q; pos_d = pos_q; rng_d = rng_q;
    cv_d = cv_q; hits_d = hits_q; mask_d = mask_q; i_d = i_q; qc_d = qc_q;
    n_d = n_q; fc_d = fc_q;
    ovld_d = (ovld_q && !out_stall_i) ? 1'b0 : ovld_q;
    prev_d = prev_q; dur_d = dur_q; num_d = num_q; neg_d = neg_q; up_d = up_q;
    prod_d = prod_q; sv_d = sv_q; sr_d = sr_q; sb_d = sb_q; v_d = v_q;
    r_d = r_q; y_d = y_q; res_d = res_q; root_d = root_q; mb_d = mb_q;
    oitem_d = oitem_q;
    ring_we = 1'b0; cell_we = 1'b0;
    diff = TB'(cmd_i.t - last_q);
    off32 = 32'(ring_rd_q - prev_q);
    mag = off32[31] ? 32'(-off32) : off32;
    nxt = xs32(rng_q);
    tgt = (34'(ohrg_pkg::ONE_Q16 - cfg_i.decay) << 16)
          - 34'(ohrg_pkg::ONE_Q16 - cfg_i.decay);
    sum = prod_q + (hits_q[i_q[2:0]] ? tgt : 34'd0) + 34'd32768;
    cell_wd = sum[31:16];
    st = sr_q + sb_q;
    p = up_q ? 18'((18'(ohrg_pkg::ONE_Q16) + 18'(res_q)) >> 1)
             : 18'((18'(ohrg_pkg::ONE_Q16) - 18'(res_q)) >> 1);
    j = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (mask_q[b]) j = 3'(b);
    end
    rest = mask_q & ~(8'd1 << j);

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            ohrg_pkg::CMD_ONSET: begin
              ring_we = 1'b1;
              wp_d = wrap(wp_q);
              if (cnt_q == CW'(ONSET_DEPTH)) rp_d = wrap(rp_q);
              else cnt_d = CW'(cnt_q + 1'b1);
            end
            ohrg_pkg::CMD_BEAT: begin
              if (!diff[31] && diff[31:0] != 32'd0) begin
                last_d = cmd_i.t;
                seen_d = 1'b1;
                prev_d = last_q;
                dur_d = diff[30:0];
                hits_d = '0;
                if (seen_q) state_d = ST_RING;
              end
            end
            ohrg_pkg::CMD_CLEAR: begin
              cv_d = '0; pos_d = '0; wp_d = '0; rp_d = '0; cnt_d = '0;
              rng_d = cfg_i.seed;
            end
            default: ;
          endcase
        end
      end
      ST_RING: begin
        i_d = '0;
        state_d = (cnt_q == '0) ? ST_DRD : ST_OFF;
      end
      ST_OFF: begin
        neg_d = off32[31];
        num_d = 36'({mag, 1'b0}) * 36'(cfg_i.subdiv) + 36'(dur_q);
        qc_d = '0;
        state_d = ST_QNT;
      end
      ST_QNT: begin
        if (num_q >= den && qc_q < cfg_i.subdiv) begin
          num_d = num_q - den;
          qc_d = 4'(qc_q + 1'b1);
        end else if (!neg_q && qc_q >= cfg_i.subdiv) begin
          i_d = '0;
          state_d = ST_DRD;
        end else begin
          if (!neg_q) hits_d[qc_q[2:0]] = 1'b1;
          else if (qc_q == 4'd0) hits_d[0] = 1'b1;
          rp_d = wrap(rp_q);
          cnt_d = CW'(cnt_q - 1'b1);
          state_d = ST_RING;
        end
      end
      ST_DRD: state_d = ST_DMUL;
      ST_DMUL: begin
        prod_d = 34'(x * cfg_i.decay);
        state_d = ST_DWR;
      end
      ST_DWR: begin
        cell_we = 1'b1;
        cv_d[caddr] = 1'b1;
        i_d = 4'(i_q + 1'b1);
        if (4'(i_q + 1'b1) == cfg_i.subdiv) begin
          v_d = 7'(pos_q) + 7'(cfg_i.subdiv);
          state_d = ST_ADV;
        end else begin
          state_d = ST_DRD;
        end
      end
      ST_ADV: begin
        if (v_q >= m) begin
          v_d = 7'(v_q - m);
        end else begin
          pos_d = v_q[AW-1:0];
          i_d = '0;
          mask_d = '0;
          state_d = ST_GRD;
        end
      end
      ST_GRD: begin
        rng_d = nxt;
        r_d = nxt[31:16];
        state_d = ST_GX;
      end
      ST_GX: begin
        up_d = x[15] ^ cfg_i.inv;
        y_d = x[15] ? 17'({x, 1'b0} - ohrg_pkg::ONE_Q16)
                    : 17'(ohrg_pkg::ONE_Q16 - {x, 1'b0});
        res_d = ohrg_pkg::ONE_Q16;
        n_d = cfg_i.expo[11:8];
        fc_d = '0;
        root_d = x[15] ? 17'({x, 1'b0} - ohrg_pkg::ONE_Q16)
                       : 17'(ohrg_pkg::ONE_Q16 - {x, 1'b0});
        state_d = ST_INT;
      end
      ST_INT: begin
        if (n_q != 4'd0) begin
          n_d = 4'(n_q - 1'b1);
          mb_d = y_q;
          ret_d = ST_INT;
          state_d = ST_MUL;
        end else begin
          state_d = ST_SQS;
        end
      end
      ST_SQS: begin
        if (fc_q == 4'd8) begin
          state_d = ST_PROB;
        end else begin
          sv_d = 34'(root_q) << 16;
          sr_d = '0;
          sb_d = 34'd1 << 32;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        if (sv_q >= st) begin
          sv_d = sv_q - st;
          sr_d = (sr_q >> 1) + sb_q;
        end else begin
          sr_d = sr_q >> 1;
        end
        sb_d = sb_q >> 2;
        if (sb_q[0]) state_d = ST_SQE;
      end
      ST_SQE: begin
        root_d = sr_q[16:0];
        fc_d = 4'(fc_q + 1'b1);
        if (cfg_i.expo[3'(~fc_q[2:0])]) begin
          mb_d = sr_q[16:0];
          ret_d = ST_SQS;
          state_d = ST_MUL;
        end else begin
          state_d = ST_SQS;
        end
      end
      ST_MUL: begin
        prod_d = 34'(res_q * mb_q);
        state_d = ST_RND;
      end
      ST_RND: begin
        res_d = 17'((prod_q + 34'd32768) >> 16);
        state_d = ret_q;
      end
      ST_PROB: begin
        if (p > 18'(r_q)) mask_d[i_q[2:0]] = 1'b1;
        i_d = 4'(i_q + 1'b1);
        state_d = (4'(i_q + 1'b1) == cfg_i.subdiv) ? ST_EMIT : ST_GRD;
      end
      ST_EMIT: begin
        if (mask_q == '0) begin
          state_d = ST_IDLE;
        end else if (free) begin
          oitem_d.slot = j;
          oitem_d.last = (rest == '0);
          ovld_d = 1'b1;
          mask_d = rest;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      seen_q  <= 1'b0;
      last_q  <= '0;
      wp_q    <= '0;
      rp_q    <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
      rng_q   <= ohrg_pkg::SEED_RESET;
      cv_q    <= '0;
      hits_q  <= '0;
      mask_q  <= '0;
      i_q     <= '0;
      qc_q    <= '0;
      n_q     <= '0;
      fc_q    <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      seen_q  <= seen_d;
      last_q  <= last_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      rng_q   <= rng_d;
      cv_q    <= cv_d;
      hits_q  <= hits_d;
      mask_q  <= mask_d;
      i_q     <= i_d;
      qc_q    <= qc_d;
      n_q     <= n_d;
      fc_q    <= fc_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q  <= prev_d;
    dur_q   <= dur_d;
    num_q   <= num_d;
    neg_q   <= neg_d;
    up_q    <= up_d;
    prod_q  <= prod_d;
    sv_q    <= sv_d;
    sr_q    <= sr_d;
    sb_q    <= sb_d;
    v_q     <= v_d;
    r_q     <= r_d;
    y_q     <= y_d;
    res_q   <= res_d;
    root_q  <= root_d;
    mb_q    <= mb_d;
    oitem_q <= oitem_d;
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[wp_q] <= cmd_i.t;
    ring_rd_q <= ring_mem[rp_q];
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) cell_mem[caddr] <= cell_wd;
    cell_rd_q <= cell_mem[caddr];
  end

endmodule
`default_nettype wire
